@@ hdl/ecr_pkg.sv @@
// shared types, widths and helpers for the two-disc elastic collision datapath
`timescale 1ns / 1ps
package ecr_pkg;

  localparam int NUM_W     = 132;            // 2*m*|dot|*|d| numerator
  localparam int DEN_W     = 99;             // (m1+m2)*|d|^2
  localparam int Q_W       = 35;             // quotient bits resolved before clamping
  localparam int CMP_W     = DEN_W + Q_W;    // width of the shifted divisor
  localparam int TERM_W    = 34;             // clamped correction magnitude
  localparam int NLANE     = 4;
  localparam int FRONT_LAT = 3;
  localparam int MULT_LAT  = 4;
  localparam int DIV_LAT   = Q_W + 2;
  localparam int PIPE_LAT  = FRONT_LAT + MULT_LAT + DIV_LAT + 1;

  localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic        [31:0] m1;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic        [31:0] m2;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               coinc;
    logic               pass;
  } side_t;

  typedef struct packed {
    logic [65:0] dotmag;
    logic        sdot;
    logic [65:0] dsq;
    logic [32:0] msum;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [32:0] adx;
    logic [32:0] ady;
    logic        sdx;
    logic        sdy;
  } geo_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
  } lane_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
      return x[31:0];
    end
    return x[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

@@ hdl/ecr_front.sv @@
// geometry stages: differences, squares and the signed relative dot product
`timescale 1ns / 1ps
module ecr_front
  import ecr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  pair_t in_pair,
  output logic  out_vld,
  output geo_t  out_geo,
  output side_t out_side
);

  // stage a
  logic               a_vld_r;
  side_t              a_side_r;
  logic signed [32:0] a_dx_r, a_dy_r, a_ux_r, a_uy_r;
  logic        [32:0] a_msum_r;
  logic        [31:0] a_m1_r, a_m2_r;

  // stage b
  logic        b_vld_r;
  side_t       b_side_r;
  logic [65:0] b_pux_r, b_puy_r, b_pdx_r, b_pdy_r;
  logic        b_sux_r, b_suy_r, b_sdx_r, b_sdy_r;
  logic [32:0] b_adx_r, b_ady_r, b_msum_r;
  logic [31:0] b_m1_r, b_m2_r;

  // stage c
  logic        c_vld_r;
  side_t       c_side_r;
  geo_t        c_geo_r;

  logic        coinc;
  logic        [32:0] adx, ady, aux, auy;
  logic signed [66:0] tx, ty, dots;

  assign coinc = (in_pair.p1x == in_pair.p2x) && (in_pair.p1y == in_pair.p2y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_dx_r         <= 33'(in_pair.p2x) - 33'(in_pair.p1x);
    a_dy_r         <= 33'(in_pair.p2y) - 33'(in_pair.p1y);
    a_ux_r         <= 33'(in_pair.v1x) - 33'(in_pair.v2x);
    a_uy_r         <= 33'(in_pair.v1y) - 33'(in_pair.v2y);
    a_msum_r       <= {1'b0, in_pair.m1} + {1'b0, in_pair.m2};
    a_m1_r         <= in_pair.m1;
    a_m2_r         <= in_pair.m2;
    a_side_r.v1x   <= in_pair.v1x;
    a_side_r.v1y   <= in_pair.v1y;
    a_side_r.v2x   <= in_pair.v2x;
    a_side_r.v2y   <= in_pair.v2y;
    a_side_r.coinc <= coinc;
    a_side_r.pass  <= coinc || (in_pair.m1 == 32'd0 && in_pair.m2 == 32'd0);
  end

  always_comb begin
    adx = mag33(a_dx_r);
    ady = mag33(a_dy_r);
    aux = mag33(a_ux_r);
    auy = mag33(a_uy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_pux_r  <= 66'(aux) * 66'(adx);
    b_puy_r  <= 66'(auy) * 66'(ady);
    b_pdx_r  <= 66'(adx) * 66'(adx);
    b_pdy_r  <= 66'(ady) * 66'(ady);
    b_sux_r  <= a_ux_r[32] ^ a_dx_r[32];
    b_suy_r  <= a_uy_r[32] ^ a_dy_r[32];
    b_sdx_r  <= a_dx_r[32];
    b_sdy_r  <= a_dy_r[32];
    b_adx_r  <= adx;
    b_ady_r  <= ady;
    b_msum_r <= a_msum_r;
    b_m1_r   <= a_m1_r;
    b_m2_r   <= a_m2_r;
    b_side_r <= a_side_r;
  end

  // signed sum of the two projected products
  always_comb begin
    tx   = b_sux_r ? -$signed({1'b0, b_pux_r}) : $signed({1'b0, b_pux_r});
    ty   = b_suy_r ? -$signed({1'b0, b_puy_r}) : $signed({1'b0, b_puy_r});
    dots = tx + ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_geo_r.dotmag <= dots[66] ? 66'(-dots) : 66'(dots);
    c_geo_r.sdot   <= dots[66];
    c_geo_r.dsq    <= b_pdx_r + b_pdy_r;
    c_geo_r.msum   <= b_msum_r;
    c_geo_r.m1     <= b_m1_r;
    c_geo_r.m2     <= b_m2_r;
    c_geo_r.adx    <= b_adx_r;
    c_geo_r.ady    <= b_ady_r;
    c_geo_r.sdx    <= b_sdx_r;
    c_geo_r.sdy    <= b_sdy_r;
    c_side_r       <= b_side_r;
  end

  assign out_vld  = c_vld_r;
  assign out_geo  = c_geo_r;
  assign out_side = c_side_r;

endmodule

@@ hdl/ecr_mult.sv @@
// product stages: denominator and the four numerators from split partial products
`timescale 1ns / 1ps
module ecr_mult
  import ecr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  geo_t             in_geo,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [DEN_W-1:0] out_den,
  output lane_t            out_lane [NLANE],
  output side_t            out_side
);

  // stage d
  logic        d_vld_r;
  side_t       d_side_r;
  logic [65:0] d_den_lo_r, d_den_hi_r, d_n2_lo_r, d_n2_hi_r, d_n1_lo_r, d_n1_hi_r;
  logic [32:0] d_adx_r, d_ady_r;
  logic        d_neg_x_r, d_neg_y_r;

  // stage e
  logic             e_vld_r;
  side_t            e_side_r;
  logic [DEN_W-1:0] e_den_r, e_nm2_r, e_nm1_r;
  logic [32:0]      e_adx_r, e_ady_r;
  logic             e_neg_x_r, e_neg_y_r;

  // stage f
  logic             f_vld_r;
  side_t            f_side_r;
  logic [DEN_W-1:0] f_den_r;
  logic [65:0]      f_pp_r [NLANE][3];
  logic             f_neg_r [NLANE];

  // stage g
  logic             g_vld_r;
  side_t            g_side_r;
  logic [DEN_W-1:0] g_den_r;
  lane_t            g_lane_r [NLANE];

  logic [32:0] m1x2, m2x2;

  assign m1x2 = {in_geo.m1, 1'b0};
  assign m2x2 = {in_geo.m2, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= in_vld;
    end
    d_den_lo_r <= 66'(in_geo.dsq[32:0])     * 66'(in_geo.msum);
    d_den_hi_r <= 66'(in_geo.dsq[65:33])    * 66'(in_geo.msum);
    d_n2_lo_r  <= 66'(in_geo.dotmag[32:0])  * 66'(m2x2);
    d_n2_hi_r  <= 66'(in_geo.dotmag[65:33]) * 66'(m2x2);
    d_n1_lo_r  <= 66'(in_geo.dotmag[32:0])  * 66'(m1x2);
    d_n1_hi_r  <= 66'(in_geo.dotmag[65:33]) * 66'(m1x2);
    d_adx_r    <= in_geo.adx;
    d_ady_r    <= in_geo.ady;
    d_neg_x_r  <= in_geo.sdot ^ in_geo.sdx;
    d_neg_y_r  <= in_geo.sdot ^ in_geo.sdy;
    d_side_r   <= in_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
    e_den_r   <= DEN_W'(d_den_lo_r) + (DEN_W'(d_den_hi_r) << 33);
    e_nm2_r   <= DEN_W'(d_n2_lo_r)  + (DEN_W'(d_n2_hi_r)  << 33);
    e_nm1_r   <= DEN_W'(d_n1_lo_r)  + (DEN_W'(d_n1_hi_r)  << 33);
    e_adx_r   <= d_adx_r;
    e_ady_r   <= d_ady_r;
    e_neg_x_r <= d_neg_x_r;
    e_neg_y_r <= d_neg_y_r;
    e_side_r  <= d_side_r;
  end

  // lanes: first x, first y (second mass), second x, second y (first mass)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
    for (int l = 0; l < NLANE; l++) begin
      for (int j = 0; j < 3; j++) begin
        f_pp_r[l][j] <= 66'((l < 2) ? e_nm2_r[33*j +: 33] : e_nm1_r[33*j +: 33]) *
                        66'((l % 2 == 1) ? e_ady_r : e_adx_r);
      end
      f_neg_r[l] <= (l % 2 == 1) ? e_neg_y_r : e_neg_x_r;
    end
    f_den_r  <= e_den_r;
    f_side_r <= e_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= f_vld_r;
    end
    for (int l = 0; l < NLANE; l++) begin
      g_lane_r[l].num <= NUM_W'(f_pp_r[l][0]) + (NUM_W'(f_pp_r[l][1]) << 33) +
                         (NUM_W'(f_pp_r[l][2]) << 66);
      g_lane_r[l].neg <= f_neg_r[l];
    end
    g_den_r  <= f_den_r;
    g_side_r <= f_side_r;
  end

  assign out_vld  = g_vld_r;
  assign out_den  = g_den_r;
  assign out_lane = g_lane_r;
  assign out_side = g_side_r;

endmodule

@@ hdl/ecr_div.sv @@
// pipelined restoring divider, one quotient bit a stage, with rounding and clamp
`timescale 1ns / 1ps
module ecr_div
  import ecr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic              in_neg,
  output logic              out_vld,
  output logic [TERM_W-1:0] out_mag,
  output logic              out_neg
);

  logic             vld_r [Q_W+1];
  logic [NUM_W-1:0] rem_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic             neg_r [Q_W+1];
  logic             ovf_r [Q_W+1];

  logic              o_vld_r, o_neg_r;
  logic [TERM_W-1:0] o_mag_r;

  logic [CMP_W-1:0] twor;
  logic             rup, sat;
  logic [Q_W:0]     qr;

  // quotient at or above 2^Q_W clamps anyway
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0] <= in_num;
    q_r[0]   <= '0;
    den_r[0] <= in_den;
    neg_r[0] <= in_neg;
    ovf_r[0] <= CMP_W'(in_num) >= (CMP_W'(in_den) << Q_W);
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    localparam int K = Q_W - i;
    logic [CMP_W-1:0] dsh, rext;
    logic             ge;

    always_comb begin
      dsh  = CMP_W'(den_r[i-1]) << K;
      rext = CMP_W'(rem_r[i-1]);
      ge   = rext >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_r[i-1];
      end
      rem_r[i] <= ge ? NUM_W'(rext - dsh) : rem_r[i-1];
      q_r[i]   <= q_r[i-1] | (Q_W'(ge) << K);
      den_r[i] <= den_r[i-1];
      neg_r[i] <= neg_r[i-1];
      ovf_r[i] <= ovf_r[i-1];
    end
  end

  // round half away from zero, then clamp the magnitude
  always_comb begin
    twor = CMP_W'(rem_r[Q_W]) << 1;
    rup  = twor >= CMP_W'(den_r[Q_W]);
    qr   = (Q_W+1)'(q_r[Q_W]) + (Q_W+1)'(rup);
    sat  = ovf_r[Q_W] || (qr > (Q_W+1)'(TERM_LIM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= vld_r[Q_W];
    end
    o_mag_r <= sat ? TERM_LIM : TERM_W'(qr);
    o_neg_r <= neg_r[Q_W];
  end

  assign out_vld = o_vld_r;
  assign out_mag = o_mag_r;
  assign out_neg = o_neg_r;

endmodule

@@ hdl/elastic_collision_response_2d.sv @@
// top level of the two-disc elastic collision response pipeline
// Fully pipelined: a transaction can be started in every cycle and busy is a registered flag
// that drops once rst_n is released and stays low, so the throughput is one disc pair per
// clock. Each result appears for one cycle with out_valid high; the pipeline is made of
// 3 geometry stages, 4 stages of split partial products, a 37-stage divider (one
// quotient bit per stage for each of the four corrections) and one output stage. There
// is no backpressure: results must be taken as they appear. Coincident positions pass the
// velocities through with out_coincident high; two zero masses pass them through too.
`timescale 1ns / 1ps
module elastic_collision_response_2d
  import ecr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_pos_x,
  input  logic signed [31:0] in_first_pos_y,
  input  logic signed [31:0] in_first_vel_x,
  input  logic signed [31:0] in_first_vel_y,
  input  logic        [31:0] in_first_mass,
  input  logic signed [31:0] in_second_pos_x,
  input  logic signed [31:0] in_second_pos_y,
  input  logic signed [31:0] in_second_vel_x,
  input  logic signed [31:0] in_second_vel_y,
  input  logic        [31:0] in_second_mass,
  output logic               out_valid,
  output logic signed [31:0] out_first_new_vel_x,
  output logic signed [31:0] out_first_new_vel_y,
  output logic signed [31:0] out_second_new_vel_x,
  output logic signed [31:0] out_second_new_vel_y,
  output logic               out_coincident
);

  logic  busy_r;
  logic  accept;
  pair_t pair;

  logic  front_vld;
  geo_t  front_geo;
  side_t front_side;

  logic             mult_vld;
  logic [DEN_W-1:0] mult_den;
  lane_t            mult_lane [NLANE];
  side_t            mult_side;

  logic              div_vld [NLANE];
  logic [TERM_W-1:0] div_mag [NLANE];
  logic              div_neg [NLANE];

  // sideband waits alongside the divider
  side_t side_d_r [DIV_LAT];
  side_t sd;

  logic signed [34:0] term [NLANE];
  logic signed [34:0] sum  [NLANE];

  logic               valid_r, coinc_r;
  logic signed [31:0] v1x_r, v1y_r, v2x_r, v2y_r;

  // only held off while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_comb begin
    pair.p1x = in_first_pos_x;
    pair.p1y = in_first_pos_y;
    pair.v1x = in_first_vel_x;
    pair.v1y = in_first_vel_y;
    pair.m1  = in_first_mass;
    pair.p2x = in_second_pos_x;
    pair.p2y = in_second_pos_y;
    pair.v2x = in_second_vel_x;
    pair.v2y = in_second_vel_y;
    pair.m2  = in_second_mass;
  end

  ecr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_pair  (pair),
    .out_vld  (front_vld),
    .out_geo  (front_geo),
    .out_side (front_side)
  );

  ecr_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .in_geo   (front_geo),
    .in_side  (front_side),
    .out_vld  (mult_vld),
    .out_den  (mult_den),
    .out_lane (mult_lane),
    .out_side (mult_side)
  );

  // one divider per velocity component correction
  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    ecr_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (mult_vld),
      .in_num  (mult_lane[l].num),
      .in_den  (mult_den),
      .in_neg  (mult_lane[l].neg),
      .out_vld (div_vld[l]),
      .out_mag (div_mag[l]),
      .out_neg (div_neg[l])
    );
  end

  always_ff @(posedge clk) begin
    side_d_r[0] <= mult_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_d_r[i] <= side_d_r[i-1];
    end
  end

  assign sd = side_d_r[DIV_LAT-1];

  // first disc loses its correction, second disc gains it
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      term[l] = div_neg[l] ? -$signed(35'(div_mag[l])) : $signed(35'(div_mag[l]));
    end
    sum[0] = 35'(sd.v1x) - term[0];
    sum[1] = 35'(sd.v1y) - term[1];
    sum[2] = 35'(sd.v2x) + term[2];
    sum[3] = 35'(sd.v2y) + term[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= div_vld[0];
    end
    coinc_r <= div_vld[0] && sd.coinc;
    v1x_r   <= sd.pass ? sd.v1x : sat32(sum[0]);
    v1y_r   <= sd.pass ? sd.v1y : sat32(sum[1]);
    v2x_r   <= sd.pass ? sd.v2x : sat32(sum[2]);
    v2y_r   <= sd.pass ? sd.v2y : sat32(sum[3]);
  end

  assign out_valid            = valid_r;
  assign out_coincident       = coinc_r;
  assign out_first_new_vel_x  = v1x_r;
  assign out_first_new_vel_y  = v1y_r;
  assign out_second_new_vel_x = v2x_r;
  assign out_second_new_vel_y = v2y_r;

endmodule

@@ hdl/ecr_chk.sv @@
// port-level checker for the elastic collision pipeline, bound to the top level
`timescale 1ns / 1ps
module ecr_chk
  import ecr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_first_pos_x,
  input logic signed [31:0] in_first_pos_y,
  input logic signed [31:0] in_first_vel_x,
  input logic signed [31:0] in_first_vel_y,
  input logic        [31:0] in_first_mass,
  input logic signed [31:0] in_second_pos_x,
  input logic signed [31:0] in_second_pos_y,
  input logic signed [31:0] in_second_vel_x,
  input logic signed [31:0] in_second_vel_y,
  input logic        [31:0] in_second_mass,
  input logic               out_valid,
  input logic signed [31:0] out_first_new_vel_x,
  input logic signed [31:0] out_first_new_vel_y,
  input logic signed [31:0] out_second_new_vel_x,
  input logic signed [31:0] out_second_new_vel_y,
  input logic               out_coincident
);

  logic accept, same_pos;

  assign accept   = start && !busy;
  assign same_pos = (in_first_pos_x == in_second_pos_x) && (in_first_pos_y == in_second_pos_y);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("transaction result missing after pipeline latency");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result strobe without a started transaction");

  a_coinc_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && same_pos) |-> ##PIPE_LAT (out_coincident &&
      out_first_new_vel_x == $past(in_first_vel_x, PIPE_LAT) &&
      out_second_new_vel_y == $past(in_second_vel_y, PIPE_LAT)))
    else $error("coincident transaction did not pass velocities through");

  a_mass_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_first_mass == 32'd0 && in_second_mass == 32'd0) |-> ##PIPE_LAT
      (out_first_new_vel_y == $past(in_first_vel_y, PIPE_LAT) &&
       out_second_new_vel_x == $past(in_second_vel_x, PIPE_LAT)))
    else $error("zero total mass did not pass velocities through");

  a_coinc_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_coincident |-> out_valid)
    else $error("coincident flag outside a result");

endmodule

bind elastic_collision_response_2d ecr_chk u_chk (.*);
